### rtl/cfbd_pkg.sv
// cfbd_pkg: phase and error codes, shared types and the crc-15 step
// used by the decoder modules and the port checker; depends on nothing
package cfbd_pkg;

  localparam int unsigned PHASE_W = 4;
  localparam int unsigned EKIND_W = 3;
  localparam int unsigned BASE_ID_W = 11;
  localparam int unsigned EXT_ID_W = 18;
  localparam int unsigned DLC_W = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CRC_W = 15;
  localparam int unsigned FCNT_W = 7;
  localparam int unsigned RUN_W = 3;
  localparam int unsigned RCNT_W = 4;

  localparam logic [CRC_W-1:0] CRC_POLY = 15'h4599;

  // decoder phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ARB      = 4'd1;
  localparam logic [PHASE_W-1:0] PH_CTRL     = 4'd2;
  localparam logic [PHASE_W-1:0] PH_BASE     = 4'd3;
  localparam logic [PHASE_W-1:0] PH_EXT      = 4'd4;
  localparam logic [PHASE_W-1:0] PH_DATA     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_REMOTE   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_CRC      = 4'd7;
  localparam logic [PHASE_W-1:0] PH_ACK      = 4'd8;
  localparam logic [PHASE_W-1:0] PH_EOF      = 4'd9;
  localparam logic [PHASE_W-1:0] PH_IFS      = 4'd10;
  localparam logic [PHASE_W-1:0] PH_OVERLOAD = 4'd11;
  localparam logic [PHASE_W-1:0] PH_ERROR    = 4'd12;
  localparam logic [PHASE_W-1:0] PH_WAIT     = 4'd13;

  // error kinds
  localparam logic [EKIND_W-1:0] EK_NONE     = 3'd0;
  localparam logic [EKIND_W-1:0] EK_STUFF    = 3'd1;
  localparam logic [EKIND_W-1:0] EK_CRC      = 3'd2;
  localparam logic [EKIND_W-1:0] EK_CRC_DELIM = 3'd3;
  localparam logic [EKIND_W-1:0] EK_ACK      = 3'd4;
  localparam logic [EKIND_W-1:0] EK_ACK_DELIM = 3'd5;
  localparam logic [EKIND_W-1:0] EK_EOF      = 3'd6;

  typedef struct packed {
    logic [RUN_W-1:0] ones;
    logic [RUN_W-1:0] zeros;
    logic             pend;
    logic             serr;
  } cfbd_stuff_t;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase;
    logic                 frame_done;
    logic [EKIND_W-1:0]   error_kind;
    logic [BASE_ID_W-1:0] base_id;
    logic [EXT_ID_W-1:0]  ext_id;
    logic                 ide_flag;
    logic                 rtr_flag;
    logic [DLC_W-1:0]     data_length;
    logic [DATA_W-1:0]    payload;
    logic                 overload_entered;
  } cfbd_result_t;

  function automatic logic [CRC_W-1:0] crc15_step(input logic [CRC_W-1:0] crc,
                                                  input logic b);
    logic nx;
    nx = b ^ crc[CRC_W-1];
    crc15_step = {crc[CRC_W-2:0], 1'b0} ^ (nx ? CRC_POLY : '0);
  endfunction

endpackage

### rtl/cfbd_stuff_check.sv
// cfbd_stuff_check: run length tracking for bit stuffing, flags the
// stuff bit to drop and the stuff error; uses cfbd_pkg
module cfbd_stuff_check
  import cfbd_pkg::*;
(
  input  logic             enable_i,
  input  logic             bit_i,
  input  logic [RUN_W-1:0] ones_i,
  input  logic [RUN_W-1:0] zeros_i,
  output cfbd_stuff_t      stuff_o
);

  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_STUFF = RUN_W'(5);
  localparam logic [RUN_W-1:0] RUN_ERR = RUN_W'(6);

  logic [RUN_W-1:0] run;

  always_comb begin
    stuff_o.ones  = ones_i;
    stuff_o.zeros = zeros_i;
    run = '0;
    if (enable_i) begin
      if (bit_i) begin
        stuff_o.zeros = '0;
        stuff_o.ones  = (ones_i < RUN_MAX) ? ones_i + RUN_W'(1) : ones_i;
        run = stuff_o.ones;
      end else begin
        stuff_o.ones  = '0;
        stuff_o.zeros = (zeros_i < RUN_MAX) ? zeros_i + RUN_W'(1) : zeros_i;
        run = stuff_o.zeros;
      end
    end
    stuff_o.pend = enable_i && (run == RUN_STUFF);
    stuff_o.serr = enable_i && (run == RUN_ERR);
  end

endmodule

### rtl/cfbd_frame_fsm.sv
// cfbd_frame_fsm: frame decoder state, field capture, crc and the
// per-bit result registers; uses cfbd_pkg and cfbd_stuff_check
module cfbd_frame_fsm
  import cfbd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         bit_i,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  output cfbd_result_t res_o
);

  localparam logic [FCNT_W-1:0] FCNT_MAX = '1;
  localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [FCNT_W-1:0]    cnt_q, cnt_d;
  logic                 started_q, started_d;
  logic [BASE_ID_W-1:0] bid_q, bid_d;
  logic [EXT_ID_W-1:0]  eid_q, eid_d;
  logic [2:0]           ctl_q, ctl_d;
  logic [DLC_W-1:0]     len_q, len_d;
  logic [DATA_W-1:0]    pay_q, pay_d;
  logic [CRC_W-1:0]     crc_q, crc_d;
  logic [RUN_W-1:0]     ones_q, ones_d;
  logic [RUN_W-1:0]     zeros_q, zeros_d;
  logic                 skip_q, skip_d;
  logic                 cfail_q, cfail_d;
  logic [RCNT_W-1:0]    rec_q, rec_d;
  logic                 ovr_q, ovr_d;
  logic                 fd_q, fd_d;
  logic [EKIND_W-1:0]   ek_q, ek_d;
  logic                 oe_q, oe_d;

  cfbd_stuff_t st;

  cfbd_stuff_check u_stuff (
    .enable_i (started_q),
    .bit_i    (bit_i),
    .ones_i   (ones_q),
    .zeros_i  (zeros_q),
    .stuff_o  (st)
  );

  always_comb begin
    logic               go_en;
    logic [PHASE_W-1:0] go_ph;
    logic               clr;
    logic [FCNT_W-1:0]  c;
    logic [FCNT_W-1:0]  data_end;

    phase_d = phase_q;  cnt_d = cnt_q;    started_d = started_q;
    bid_d = bid_q;      eid_d = eid_q;    ctl_d = ctl_q;
    len_d = len_q;      pay_d = pay_q;    crc_d = crc_q;
    ones_d = st.ones;   zeros_d = st.zeros;
    cfail_d = cfail_q;  rec_d = rec_q;    ovr_d = ovr_q;
    fd_d = 1'b0;        ek_d = EK_NONE;   oe_d = 1'b0;
    go_en = 1'b0;       go_ph = phase_q;  clr = 1'b0;
    c = cnt_q;
    data_end = '0;

    if (st.serr) begin
      started_d = 1'b0;
      ek_d = EK_STUFF;
      go_en = 1'b1;
      go_ph = PH_ERROR;
    end

    if (!skip_q && !st.serr) begin
      case (phase_q)
        PH_ARB: begin
          crc_d = crc15_step(crc_q, bit_i);
          bid_d = {bid_q[BASE_ID_W-2:0], bit_i};
          if (c >= FCNT_W'(10)) begin
            go_en = 1'b1; go_ph = PH_CTRL;
          end else begin
            cnt_d = c + FCNT_W'(1);
          end
        end
        PH_CTRL: begin
          crc_d = crc15_step(crc_q, bit_i);
          if (c == '0) begin
            ctl_d[0] = bit_i;
            cnt_d = c + FCNT_W'(1);
          end else begin
            ctl_d[1] = bit_i;
            go_en = 1'b1;
            go_ph = bit_i ? PH_EXT : PH_BASE;
          end
        end
        PH_BASE: begin
          crc_d = crc15_step(crc_q, bit_i);
          ctl_d[2] = ctl_q[0];
          go_en = 1'b1;
          go_ph = ctl_q[0] ? PH_REMOTE : PH_DATA;
        end
        PH_EXT: begin
          crc_d = crc15_step(crc_q, bit_i);
          if (c <= FCNT_W'(17)) eid_d = {eid_q[EXT_ID_W-2:0], bit_i};
          if (c == FCNT_W'(18)) ctl_d[2] = bit_i;
          if (c >= FCNT_W'(20)) begin
            go_en = 1'b1;
            go_ph = ctl_d[2] ? PH_REMOTE : PH_DATA;
          end else begin
            cnt_d = c + FCNT_W'(1);
          end
        end
        PH_REMOTE: begin
          crc_d = crc15_step(crc_q, bit_i);
          if (c <= FCNT_W'(3)) len_d = {len_q[DLC_W-2:0], bit_i};
          if (c >= FCNT_W'(3)) begin
            if (len_d > DLC_W'(8)) len_d = DLC_W'(8);
            go_en = 1'b1; go_ph = PH_CRC;
          end else begin
            cnt_d = c + FCNT_W'(1);
          end
        end
        PH_DATA: begin
          crc_d = crc15_step(crc_q, bit_i);
          if (c <= FCNT_W'(3)) len_d = {len_q[DLC_W-2:0], bit_i};
          if (c == FCNT_W'(3) && len_d > DLC_W'(8)) len_d = DLC_W'(8);
          // last data bit index: 3 + 8 * length
          data_end = {len_d, 3'b000} + FCNT_W'(3);
          if (c > FCNT_W'(3) && c <= data_end) pay_d = {pay_q[DATA_W-2:0], bit_i};
          if (c >= FCNT_W'(3) && c >= data_end) begin
            go_en = 1'b1; go_ph = PH_CRC;
          end else begin
            cnt_d = c + FCNT_W'(1);
          end
        end
        PH_CRC: begin
          if (c <= FCNT_W'(14)) crc_d = crc15_step(crc_q, bit_i);
          if (c == FCNT_W'(14)) begin
            if (crc_d != '0) cfail_d = 1'b1;
            started_d = 1'b0;
          end
          if (c >= FCNT_W'(15)) begin
            go_en = 1'b1;
            if (!bit_i) begin
              go_ph = PH_ERROR; ek_d = EK_CRC_DELIM;
            end else begin
              go_ph = PH_ACK;
            end
          end else begin
            cnt_d = c + FCNT_W'(1);
          end
        end
        PH_ACK: begin
          if (c == '0) begin
            if (bit_i) begin
              go_en = 1'b1; go_ph = PH_ERROR; ek_d = EK_ACK;
            end else begin
              cnt_d = c + FCNT_W'(1);
            end
          end else if (cfail_q) begin
            go_en = 1'b1; go_ph = PH_ERROR; ek_d = EK_CRC;
          end else if (!bit_i) begin
            go_en = 1'b1; go_ph = PH_ERROR; ek_d = EK_ACK_DELIM;
          end else begin
            go_en = 1'b1; go_ph = PH_EOF; fd_d = 1'b1;
          end
        end
        PH_EOF: begin
          if (!bit_i) begin
            go_en = 1'b1; go_ph = PH_ERROR; ek_d = EK_EOF;
          end else if (c >= FCNT_W'(6)) begin
            go_en = 1'b1; go_ph = ovr_q ? PH_OVERLOAD : PH_IFS;
          end else begin
            cnt_d = c + FCNT_W'(1);
          end
        end
        PH_IFS: begin
          if (c >= FCNT_W'(2)) begin
            clr = 1'b1;
          end else if (!bit_i) begin
            go_en = 1'b1; go_ph = PH_OVERLOAD; oe_d = 1'b1;
          end else begin
            cnt_d = c + FCNT_W'(1);
          end
        end
        PH_OVERLOAD, PH_ERROR: begin
          // leave with the first bit after the seventh recessive bit, consecutive or not
          if (rec_q >= RCNT_W'(7)) begin
            go_en = 1'b1; go_ph = PH_WAIT;
          end
          if (bit_i && rec_q < RCNT_MAX) rec_d = rec_q + RCNT_W'(1);
        end
        PH_WAIT: begin
          if (c >= FCNT_W'(10)) begin
            clr = 1'b1;
            if (!bit_i) begin
              go_en = 1'b1; go_ph = PH_OVERLOAD; oe_d = 1'b1;
            end
          end else if (bit_i) begin
            cnt_d = c + FCNT_W'(1);
          end else begin
            go_en = 1'b1; go_ph = PH_OVERLOAD; oe_d = 1'b1;
          end
        end
        default: begin
          // start of frame: counts as the first dominant bit
          if (!bit_i) begin
            phase_d = PH_IDLE;
            go_en = 1'b1; go_ph = PH_ARB;
            started_d = 1'b1;
            crc_d = crc15_step(crc_q, 1'b0);
            zeros_d = RUN_W'(1);
            ones_d = '0;
          end
        end
      endcase
    end

    if (clr) begin
      ovr_d = 1'b0;     phase_d = PH_IDLE; cnt_d = '0;   started_d = 1'b0;
      bid_d = '0;       eid_d = '0;        ctl_d = '0;   len_d = '0;
      pay_d = '0;       crc_d = '0;        ones_d = '0;  zeros_d = '0;
      cfail_d = 1'b0;   rec_d = '0;
    end

    if (go_en) begin
      if (go_ph == PH_OVERLOAD || go_ph == PH_ERROR) rec_d = '0;
      // wait keeps its recessive count across overload frames
      if (!(go_ph == PH_WAIT || (go_ph == PH_OVERLOAD && phase_d == PH_WAIT))) cnt_d = '0;
      phase_d = go_ph;
    end

    skip_d = st.pend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;  cnt_q <= '0;    started_q <= 1'b0;
      bid_q <= '0;         eid_q <= '0;    ctl_q <= '0;
      len_q <= '0;         pay_q <= '0;    crc_q <= '0;
      ones_q <= '0;        zeros_q <= '0;  skip_q <= 1'b0;
      cfail_q <= 1'b0;     rec_q <= '0;    ovr_q <= 1'b0;
      fd_q <= 1'b0;        ek_q <= EK_NONE; oe_q <= 1'b0;
    end else begin
      if (step_i) begin
        phase_q <= phase_d;  cnt_q <= cnt_d;    started_q <= started_d;
        bid_q <= bid_d;      eid_q <= eid_d;    ctl_q <= ctl_d;
        len_q <= len_d;      pay_q <= pay_d;    crc_q <= crc_d;
        ones_q <= ones_d;    zeros_q <= zeros_d; skip_q <= skip_d;
        cfail_q <= cfail_d;  rec_q <= rec_d;
        fd_q <= fd_d;        ek_q <= ek_d;      oe_q <= oe_d;
      end
      if (cfg_we_i) begin
        ovr_q <= cfg_wdata_i;
      end else if (step_i) begin
        ovr_q <= ovr_d;
      end
    end
  end

  assign res_o.phase            = phase_q;
  assign res_o.frame_done       = fd_q;
  assign res_o.error_kind       = ek_q;
  assign res_o.base_id          = bid_q;
  assign res_o.ext_id           = eid_q;
  assign res_o.ide_flag         = ctl_q[1];
  assign res_o.rtr_flag         = ctl_q[2];
  assign res_o.data_length      = len_q;
  assign res_o.payload          = pay_q;
  assign res_o.overload_entered = oe_q;

endmodule

### rtl/can_frame_bit_decoder_core.sv
// can_frame_bit_decoder_core: top level of the bit-serial can frame decoder
// depends on cfbd_pkg and cfbd_frame_fsm
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  bus_bit_i
//   out      source     out_valid_o/out_stall_i phase_o .. overload_entered_o
//   cfg      sink       cfg_we_i               cfg_wdata_i (overload request)
//
// one bus bit per cycle while in_stall_o is low: each accepted word is decoded
// in the cycle it is accepted and its result word is valid on the next cycle
// the decoder state registers double as the result register; the single
// feedback loop (phase, counters, crc) closes through those registers
// in_stall_o is raised only while a result word is held and out_stall_i is high
// reset is asynchronous, active low, and leaves the decoder in bus idle
module can_frame_bit_decoder_core
  import cfbd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // bit input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 bus_bit_i,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PHASE_W-1:0]   phase_o,
  output logic                 frame_done_o,
  output logic [EKIND_W-1:0]   error_kind_o,
  output logic [BASE_ID_W-1:0] base_id_o,
  output logic [EXT_ID_W-1:0]  ext_id_o,
  output logic                 ide_flag_o,
  output logic                 rtr_flag_o,
  output logic [DLC_W-1:0]     data_length_o,
  output logic [DATA_W-1:0]    payload_o,
  output logic                 overload_entered_o
);

  logic         out_valid_q, out_valid_d;
  logic         accept;
  cfbd_result_t res;

  // a held result word is replaced only once it is taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  cfbd_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .bit_i       (bus_bit_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  // result valid: set by every accepted bit, cleared once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign phase_o            = res.phase;
  assign frame_done_o       = res.frame_done;
  assign error_kind_o       = res.error_kind;
  assign base_id_o          = res.base_id;
  assign ext_id_o           = res.ext_id;
  assign ide_flag_o         = res.ide_flag;
  assign rtr_flag_o         = res.rtr_flag;
  assign data_length_o      = res.data_length;
  assign payload_o          = res.payload;
  assign overload_entered_o = res.overload_entered;

endmodule

### rtl/cfbd_checker.sv
// cfbd_checker: port level checks of the decoder top, bound to it below
// depends on cfbd_pkg and can_frame_bit_decoder_core
module cfbd_checker
  import cfbd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [PHASE_W-1:0]   phase_o,
  input logic                 frame_done_o,
  input logic [EKIND_W-1:0]   error_kind_o,
  input logic [BASE_ID_W-1:0] base_id_o,
  input logic [DATA_W-1:0]    payload_o,
  input logic                 overload_entered_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // every accepted bit yields a result word next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted bit gave no result word");

  // any reported error lands in the error phase
  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_kind_o != EK_NONE) |-> phase_o == PH_ERROR)
    else $error("error reported outside error phase");

  // frame completion moves to eof, overload start to overload
  a_pulse_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!frame_done_o || phase_o == PH_EOF)
                 && (!overload_entered_o || phase_o == PH_OVERLOAD))
    else $error("status pulse in wrong phase");

  // bus idle always shows cleared base id and payload fields
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == PH_IDLE |-> base_id_o == '0 && payload_o == '0)
    else $error("captured fields not cleared in idle");

endmodule

bind can_frame_bit_decoder_core cfbd_checker u_cfbd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .phase_o            (phase_o),
  .frame_done_o       (frame_done_o),
  .error_kind_o       (error_kind_o),
  .base_id_o          (base_id_o),
  .payload_o          (payload_o),
  .overload_entered_o (overload_entered_o)
);

### tb/sv/can_frame_bit_decoder_core_test.sv
// can_frame_bit_decoder_core_test: self-checking bench for the bit-serial can frame decoder
// builds stuffed base/extended frames with valid crc, injects faults, predicts every result word
// depends on cfbd_pkg and can_frame_bit_decoder_core
`timescale 1ns / 1ps

module can_frame_bit_decoder_core_test;
  import cfbd_pkg::*;

  // fault injected into a well-formed frame before it goes on the bus
  typedef enum int {
    FAULT_NONE,
    FAULT_FLIP,        // one bit flipped between sof and crc
    FAULT_ACK_SLOT,    // nobody acknowledges
    FAULT_ACK_DELIM,   // dominant ack delimiter
    FAULT_CRC_DELIM,   // dominant crc delimiter
    FAULT_EOF,         // dominant bit inside end of frame
    FAULT_IFS,         // dominant bit in intermission, overload
    FAULT_FLAG,        // frame cut short by an error flag
    FAULT_NOISE        // frame cut short by random bus noise
  } fault_t;

  // predicts the decoder bit by bit and holds the result words still owed
  class decode_scoreboard;
    cfbd_result_t   expected_words[$];
    int unsigned    mismatches;
    bit             ovl_req;
    logic [3:0]     cur_phase;
    logic [6:0]     bit_idx;
    bit             stuffing_on;
    logic [10:0]    id_base;
    logic [17:0]    id_ext;
    logic [2:0]     ctl;        // b0 rtr/srr slot, b1 ide, b2 rtr
    logic [3:0]     dlc_q;
    logic [63:0]    data_q;
    logic [14:0]    crc_q;
    logic [2:0]     run_ones;
    logic [2:0]     run_zeros;
    bit             skip_next;
    bit             crc_bad;
    logic [3:0]     dom_cnt;
    logic [3:0]     rec_cnt;

    function new();
      mismatches = 0;
      clear_all();
    endfunction

    static function logic [14:0] crc_next(logic [14:0] crc, bit b);
      logic [14:0] nxt;
      nxt = {crc[13:0], 1'b0};
      if (b ^ crc[14]) nxt = nxt ^ CRC_POLY;
      return nxt;
    endfunction

    // back to bus idle, the overload request drops with it
    function void clear_all();
      ovl_req = 0;
      cur_phase = PH_IDLE;
      bit_idx = '0;
      stuffing_on = 0;
      id_base = '0;
      id_ext = '0;
      ctl = '0;
      dlc_q = '0;
      data_q = '0;
      crc_q = '0;
      run_ones = '0;
      run_zeros = '0;
      skip_next = 0;
      crc_bad = 0;
      dom_cnt = '0;
      rec_cnt = '0;
    endfunction

    function void load_overload(bit v);
      ovl_req = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // overload/error restart their counts; wait keeps its bit count across overloads
    function void enter(logic [3:0] p);
      if (p == PH_OVERLOAD || p == PH_ERROR) begin
        dom_cnt = '0;
        rec_cnt = '0;
      end
      if (!(p == PH_WAIT || (p == PH_OVERLOAD && cur_phase == PH_WAIT))) bit_idx = '0;
      cur_phase = p;
    endfunction

    function void bump();
      if (bit_idx < 7'd127) bit_idx++;
    endfunction

    function void decode_bit(bit b);
      cfbd_result_t w;
      bit skip, pend, serr;
      int unsigned c, span;
      w = '0;
      skip = skip_next;
      pend = 0;
      serr = 0;
      c = bit_idx;
      // stuff run tracking, stuff bits included
      if (stuffing_on) begin
        if (b) begin
          run_zeros = '0;
          if (run_ones < 3'd7) run_ones++;
          pend = (run_ones == 3'd5);
          serr = (run_ones == 3'd6);
        end else begin
          run_ones = '0;
          if (run_zeros < 3'd7) run_zeros++;
          pend = (run_zeros == 3'd5);
          serr = (run_zeros == 3'd6);
        end
      end
      if (serr) begin
        stuffing_on = 0;
        w.error_kind = EK_STUFF;
        enter(PH_ERROR);
      end
      if (!skip && !serr) begin
        case (cur_phase)
          PH_ARB: begin
            crc_q = crc_next(crc_q, b);
            id_base = {id_base[9:0], b};
            if (c >= 10) enter(PH_CTRL);
            else bump();
          end
          PH_CTRL: begin
            crc_q = crc_next(crc_q, b);
            if (c == 0) begin
              ctl[0] = b;
              bump();
            end else begin
              ctl[1] = b;
              enter(b ? PH_EXT : PH_BASE);
            end
          end
          PH_BASE: begin
            crc_q = crc_next(crc_q, b);
            ctl[2] = ctl[0];
            enter(ctl[2] ? PH_REMOTE : PH_DATA);
          end
          PH_EXT: begin
            crc_q = crc_next(crc_q, b);
            if (c <= 17) id_ext = {id_ext[16:0], b};
            if (c == 18) ctl[2] = b;
            if (c >= 20) enter(ctl[2] ? PH_REMOTE : PH_DATA);
            else bump();
          end
          PH_REMOTE: begin
            crc_q = crc_next(crc_q, b);
            if (c <= 3) dlc_q = {dlc_q[2:0], b};
            if (c >= 3) begin
              if (dlc_q > 4'd8) dlc_q = 4'd8;
              enter(PH_CRC);
            end else begin
              bump();
            end
          end
          PH_DATA: begin
            crc_q = crc_next(crc_q, b);
            if (c <= 3) dlc_q = {dlc_q[2:0], b};
            if (c == 3 && dlc_q > 4'd8) dlc_q = 4'd8;
            span = 3 + 8 * dlc_q;
            if (c > 3 && c <= span) data_q = {data_q[62:0], b};
            if (c >= 3 && c >= span) enter(PH_CRC);
            else bump();
          end
          PH_CRC: begin
            if (c <= 14) crc_q = crc_next(crc_q, b);
            // last crc bit: residue decides, stuffing ends after it
            if (c == 14) begin
              if (crc_q != '0) crc_bad = 1;
              stuffing_on = 0;
            end
            if (c >= 15) begin
              if (!b) begin
                enter(PH_ERROR);
                w.error_kind = EK_CRC_DELIM;
              end else begin
                enter(PH_ACK);
              end
            end else begin
              bump();
            end
          end
          PH_ACK: begin
            if (c == 0) begin
              if (b) begin
                enter(PH_ERROR);
                w.error_kind = EK_ACK;
              end else begin
                bump();
              end
            end else if (crc_bad) begin
              enter(PH_ERROR);
              w.error_kind = EK_CRC;
            end else if (!b) begin
              enter(PH_ERROR);
              w.error_kind = EK_ACK_DELIM;
            end else begin
              enter(PH_EOF);
              w.frame_done = 1'b1;
            end
          end
          PH_EOF: begin
            if (!b) begin
              enter(PH_ERROR);
              w.error_kind = EK_EOF;
            end else if (c >= 6) begin
              enter(ovl_req ? PH_OVERLOAD : PH_IFS);
            end else begin
              bump();
            end
          end
          PH_IFS: begin
            if (c >= 2) begin
              clear_all();
            end else if (!b) begin
              enter(PH_OVERLOAD);
              w.overload_entered = 1'b1;
            end else begin
              bump();
            end
          end
          PH_OVERLOAD, PH_ERROR: begin
            if (rec_cnt >= 4'd7) enter(PH_WAIT);
            if (b) begin
              if (rec_cnt < 4'd15) rec_cnt++;
            end else if (dom_cnt < 4'd15) begin
              dom_cnt++;
            end
          end
          PH_WAIT: begin
            if (c >= 10) begin
              clear_all();
              if (!b) begin
                enter(PH_OVERLOAD);
                w.overload_entered = 1'b1;
              end
            end else if (b) begin
              bump();
            end else begin
              enter(PH_OVERLOAD);
              w.overload_entered = 1'b1;
            end
          end
          default: begin
            // start of frame, counts as the first dominant bit
            if (!b) begin
              cur_phase = PH_IDLE;
              enter(PH_ARB);
              stuffing_on = 1;
              crc_q = crc_next(crc_q, 1'b0);
              run_zeros = 3'd1;
              run_ones = '0;
            end
          end
        endcase
      end
      skip_next = pend;

      w.phase = cur_phase;
      w.base_id = id_base;
      w.ext_id = id_ext;
      w.ide_flag = ctl[1];
      w.rtr_flag = ctl[2];
      w.data_length = dlc_q;
      w.payload = data_q;
      expected_words.push_back(w);
    endfunction

    task report(string what);
      if (mismatches < 200) $display("%0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_word(cfbd_result_t got);
      cfbd_result_t want;
      if (expected_words.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = expected_words.pop_front();
      if (got.phase !== want.phase)
        report($sformatf("phase got %0d want %0d", got.phase, want.phase));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done got %0b want %0b", got.frame_done, want.frame_done));
      if (got.error_kind !== want.error_kind)
        report($sformatf("error_kind got %0d want %0d", got.error_kind, want.error_kind));
      if (got.base_id !== want.base_id)
        report($sformatf("base_id got %h want %h", got.base_id, want.base_id));
      if (got.ext_id !== want.ext_id)
        report($sformatf("ext_id got %h want %h", got.ext_id, want.ext_id));
      if (got.ide_flag !== want.ide_flag)
        report($sformatf("ide_flag got %0b want %0b", got.ide_flag, want.ide_flag));
      if (got.rtr_flag !== want.rtr_flag)
        report($sformatf("rtr_flag got %0b want %0b", got.rtr_flag, want.rtr_flag));
      if (got.data_length !== want.data_length)
        report($sformatf("data_length got %0d want %0d", got.data_length, want.data_length));
      if (got.payload !== want.payload)
        report($sformatf("payload got %h want %h", got.payload, want.payload));
      if (got.overload_entered !== want.overload_entered)
        report($sformatf("overload_entered got %0b want %0b",
                         got.overload_entered, want.overload_entered));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 bus_bit_i;
  logic                 cfg_we_i;
  logic                 cfg_wdata_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PHASE_W-1:0]   phase_o;
  logic                 frame_done_o;
  logic [EKIND_W-1:0]   error_kind_o;
  logic [BASE_ID_W-1:0] base_id_o;
  logic [EXT_ID_W-1:0]  ext_id_o;
  logic                 ide_flag_o;
  logic                 rtr_flag_o;
  logic [DLC_W-1:0]     data_length_o;
  logic [DATA_W-1:0]    payload_o;
  logic                 overload_entered_o;

  decode_scoreboard sb;
  int unsigned      idle_pct;     // chance per cycle that the bit source holds off
  int unsigned      stall_pct;    // chance per cycle that the result sink stalls
  bit               wire_q[$];    // bits of the current frame as they appear on the bus
  int unsigned      delim_at;     // position of the crc delimiter in wire_q
  bit               tail_stuff;   // a stuff bit follows the last crc bit
  int unsigned      random_bits;
  int unsigned      tries;

  can_frame_bit_decoder_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .bus_bit_i          (bus_bit_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .phase_o            (phase_o),
    .frame_done_o       (frame_done_o),
    .error_kind_o       (error_kind_o),
    .base_id_o          (base_id_o),
    .ext_id_o           (ext_id_o),
    .ide_flag_o         (ide_flag_o),
    .rtr_flag_o         (rtr_flag_o),
    .data_length_o      (data_length_o),
    .payload_o          (payload_o),
    .overload_entered_o (overload_entered_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result sink: random stall, sampled against pre-edge values
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // every accepted result word is compared with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({phase_o, frame_done_o, error_kind_o, base_id_o, ext_id_o, ide_flag_o,
                     rtr_flag_o, data_length_o, payload_o, overload_entered_o});
  end

  // hard stop in case the handshake locks up
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // one bus bit as one input word; returns at the edge that accepted it
  task automatic send_bit(input bit b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    bus_bit_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.decode_bit(b);
  endtask

  task automatic send_wire();
    foreach (wire_q[i]) send_bit(wire_q[i]);
  endtask

  // overload request is written only with no result word outstanding
  task automatic write_overload(input bit v);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.load_overload(v);
  endtask

  // enough recessive bits to reach bus idle from any phase, sometimes with a stray
  // dominant bit first at a random spot of the error, overload or wait phase
  task automatic recover();
    repeat ($urandom_range(24)) send_bit(1'b1);
    if ($urandom_range(1)) send_bit(1'b0);
    repeat (40) send_bit(1'b1);
  endtask

  // sof..crc with stuffing, then delimiters, eof and intermission
  function automatic void build_frame(bit ext, bit rtr, logic [10:0] id, logic [17:0] eid,
                                      logic [3:0] dlc, logic [63:0] data, logic [2:0] spare);
    bit          raw[$];
    logic [14:0] crc;
    int          nbytes;
    int unsigned run;
    bit          last;
    wire_q.delete();
    raw.push_back(1'b0);
    for (int i = 10; i >= 0; i--) raw.push_back(id[i]);
    if (ext) begin
      raw.push_back(spare[2]);   // srr
      raw.push_back(1'b1);       // ide
      for (int i = 17; i >= 0; i--) raw.push_back(eid[i]);
      raw.push_back(rtr);
      raw.push_back(spare[1]);   // r1
      raw.push_back(spare[0]);   // r0
    end else begin
      raw.push_back(rtr);
      raw.push_back(1'b0);
      raw.push_back(spare[0]);
    end
    for (int i = 3; i >= 0; i--) raw.push_back(dlc[i]);
    nbytes = rtr ? 0 : ((dlc > 4'd8) ? 8 : int'(dlc));
    for (int i = nbytes * 8 - 1; i >= 0; i--) raw.push_back(data[i]);
    crc = '0;
    foreach (raw[i]) crc = decode_scoreboard::crc_next(crc, raw[i]);
    for (int i = 14; i >= 0; i--) raw.push_back(crc[i]);
    run = 0;
    last = 1'b1;
    tail_stuff = 0;
    foreach (raw[i]) begin
      wire_q.push_back(raw[i]);
      tail_stuff = 0;
      if (raw[i] == last) run++;
      else begin
        run = 1;
        last = raw[i];
      end
      if (run == 5) begin
        wire_q.push_back(!last);
        last = !last;
        run = 1;
        tail_stuff = 1;
      end
    end
    delim_at = wire_q.size();
    wire_q.push_back(1'b1);   // crc delimiter
    wire_q.push_back(1'b0);   // ack slot
    wire_q.push_back(1'b1);   // ack delimiter
    repeat (10) wire_q.push_back(1'b1);   // eof and intermission
  endfunction

  function automatic void random_frame();
    logic [3:0] dlc;
    dlc = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
    build_frame($urandom_range(1), ($urandom_range(3) == 0), 11'($urandom_range(2047)),
                18'($urandom_range(262143)), dlc, {$urandom, $urandom}, 3'($urandom_range(7)));
  endfunction

  // inject the fault, put the frame on the bus, then idle or recover
  task automatic play_frame(input fault_t fault);
    bit          long_tail;
    int unsigned cut;
    long_tail = (fault != FAULT_NONE) || sb.ovl_req;
    cut = $urandom_range(delim_at, 1);
    case (fault)
      FAULT_FLIP:      wire_q[cut - 1] = !wire_q[cut - 1];
      FAULT_ACK_SLOT:  wire_q[delim_at + 1] = 1'b1;
      FAULT_ACK_DELIM: wire_q[delim_at + 2] = 1'b0;
      FAULT_CRC_DELIM: wire_q[delim_at] = 1'b0;
      FAULT_EOF:       wire_q[delim_at + 3 + $urandom_range(6)] = 1'b0;
      FAULT_IFS:       wire_q[delim_at + 10 + $urandom_range(1)] = 1'b0;
      FAULT_FLAG, FAULT_NOISE: begin
        while (wire_q.size() > cut) wire_q.delete(wire_q.size() - 1);
        if (fault == FAULT_FLAG) repeat (6) wire_q.push_back(1'b0);
        else repeat (20) wire_q.push_back($urandom_range(1));
      end
      default: ;
    endcase
    send_wire();
    if (long_tail) recover();
    else repeat ($urandom_range(2)) send_bit(1'b1);
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    bus_bit_i <= 1'b1;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, both formats, data and remote, long dlc
    write_overload(1'b0);
    repeat (3) send_bit(1'b1);
    build_frame(0, 0, 11'h000, '0, 4'd0, '0, 3'b000);
    play_frame(FAULT_NONE);
    build_frame(0, 0, 11'h7ff, '0, 4'd8, {64{1'b1}}, 3'b111);
    play_frame(FAULT_NONE);
    build_frame(1, 0, 11'h000, 18'h00000, 4'd15, 64'h0, 3'b000);
    play_frame(FAULT_NONE);
    build_frame(1, 0, 11'h7ff, 18'h3ffff, 4'd8, 64'ha5a5_5a5a_f0f0_0f0f, 3'b111);
    play_frame(FAULT_NONE);
    build_frame(0, 1, 11'h555, '0, 4'd15, '0, 3'b001);
    play_frame(FAULT_NONE);
    build_frame(1, 1, 11'h2aa, 18'h15555, 4'd3, '0, 3'b110);
    play_frame(FAULT_NONE);

    // overload request: overload frame instead of intermission
    write_overload(1'b1);
    build_frame(0, 0, 11'h123, '0, 4'd1, 64'h5a, 3'b000);
    play_frame(FAULT_NONE);

    // every fault once: crc, ack, delimiter and eof errors, overload, flags, noise
    for (int k = FAULT_FLIP; k <= FAULT_NOISE; k++) begin
      random_frame();
      play_frame(fault_t'(k));
    end

    // sixth recessive after sof is a stuff error; after error delimiter and
    // ten wait bits a dominant eleventh bit starts an overload frame
    wire_q.delete();
    wire_q.push_back(1'b0);
    repeat (6 + 8 + 10) wire_q.push_back(1'b1);
    wire_q.push_back(1'b0);
    send_wire();
    repeat (40) send_bit(1'b1);

    // crc sequence ending in five equal bits, stuff bit before the delimiter
    tries = 0;
    do begin
      build_frame(0, 0, 11'($urandom_range(2047)), '0, 4'($urandom_range(2)),
                  {$urandom, $urandom}, 3'($urandom_range(7)));
      tries++;
    end while (!tail_stuff && tries < 2000);
    play_frame(FAULT_NONE);

    // random: mostly well-formed frames, some faulted, some bus noise;
    // four idling phases in turn
    random_bits = 0;
    while (random_bits < 1350) begin
      case (random_bits * 4 / 1350)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      if ($urandom_range(3) == 0) write_overload($urandom_range(1));
      if ($urandom_range(9) == 0) begin
        wire_q.delete();
        repeat (30) wire_q.push_back($urandom_range(1));
        random_bits += 30;
        send_wire();
        recover();
      end else begin
        random_frame();
        random_bits += wire_q.size();
        play_frame(($urandom_range(9) < 6) ? FAULT_NONE
                                           : fault_t'($urandom_range(FAULT_NOISE, FAULT_FLIP)));
      end
    end

    // drain, then keep the clock running to catch stray result words
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### can_frame_bit_decoder_core.f
rtl/cfbd_pkg.sv
rtl/cfbd_stuff_check.sv
rtl/cfbd_frame_fsm.sv
rtl/can_frame_bit_decoder_core.sv
rtl/cfbd_checker.sv
tb/sv/can_frame_bit_decoder_core_test.sv
